[rtl/core/ptd_pkg.sv]
// Shared constants and types of the Pythagorean triplet detector.
`default_nettype none
package ptd_pkg;
   localparam int MAX_ITEMS = 1024;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int WIDE_W    = CNT_W + 1;
   localparam int VAL_W     = 32;
   localparam int SQ_W      = 63;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [SQ_W-1:0]  data;
   } ram_wr_type;
endpackage
`default_nettype wire

[rtl/core/ptd_ram.sv]
// Generic memory with one write port and two registered read ports.
`default_nettype none
module ptd_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 63
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule
`default_nettype wire

[rtl/core/ptd_squarer.sv]
// Magnitude and square of each accepted value, registered as a store write.
`default_nettype none
module ptd_squarer
   import ptd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             take,
   input  wire logic [VAL_W-1:0] value,
   input  wire logic [IDX_W-1:0] addr,
   output ram_wr_type            wr
);
   logic [VAL_W-1:0]   mag;
   logic [2*VAL_W-1:0] prod;
   ram_wr_type         wr_ff, wr_in;

   always_comb begin
      mag        = value[VAL_W-1] ? (~value + VAL_W'(1)) : value;
      prod       = mag * mag;
      wr_in.en   = take;
      wr_in.addr = addr;
      wr_in.data = prod[SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff.en <= 1'b0;
      end else begin
         wr_ff.en <= wr_in.en;
      end
      wr_ff.addr <= wr_in.addr;
      wr_ff.data <= wr_in.data;
   end

   assign wr = wr_ff;
endmodule
`default_nettype wire

[rtl/core/pythagorean_triplet_detector.sv]
// Top level of the Pythagorean triplet detector: load, merge sort and search sequencer.
// The block takes one value per cycle while loading and squares it into a 1024-entry store.
// The item marked last starts a bottom-up merge sort that ping-pongs between two memories
// over ceil(log2 n) passes, followed by a two-pointer search of at most about n*n/2 steps.
// Input is stalled from the last item until the single result (found, overflowed) is loaded
// into the output register; items beyond 1024 are dropped and reported through overflowed.
`default_nettype none
module pythagorean_triplet_detector
   import ptd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // value[31:0]
   input  wire logic        req_tlast,  // last_item
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata   // found[0], overflowed[1], zeros above
);
   localparam logic [3:0] ST_LOAD = 4'd0;
   localparam logic [3:0] ST_PASS = 4'd1;
   localparam logic [3:0] ST_RUN  = 4'd2;
   localparam logic [3:0] ST_MRD  = 4'd3;
   localparam logic [3:0] ST_MWR  = 4'd4;
   localparam logic [3:0] ST_SINI = 4'd5;
   localparam logic [3:0] ST_STOP = 4'd6;
   localparam logic [3:0] ST_STGT = 4'd7;
   localparam logic [3:0] ST_SLP  = 4'd8;
   localparam logic [3:0] ST_SCMP = 4'd9;
   localparam logic [3:0] ST_DONE = 4'd10;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop_ff, drop_in;
   logic             src_ff, src_in;
   logic [WIDE_W-1:0] w_ff, w_in, lo_ff, lo_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, mid_ff, mid_in, hi_ff, hi_in;
   logic [CNT_W-1:0] top_ff, top_in, left_ff, left_in, right_ff, right_in;
   logic [SQ_W-1:0]  target_ff, target_in;
   logic             found_ff, found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_data_ff, rsp_data_in;

   logic             accept, store_it;
   ram_wr_type       sq_wr;
   logic [IDX_W-1:0] rd_a, rd_b;
   logic [SQ_W-1:0]  b0_a, b0_b, b1_a, b1_b, da, db;
   logic             merge_we, take_i, can_load;
   logic [SQ_W-1:0]  merge_data;
   logic [SQ_W:0]    sum;
   logic [WIDE_W-1:0] n_wide, lo_w, lo_2w;
   ram_wr_type       b0_wr;

   assign req_tready = (state_ff == ST_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign store_it   = accept && (count_ff < CNT_W'(MAX_ITEMS));
   assign can_load   = !rsp_valid_ff || rsp_tready;

   ptd_squarer u_sq (
      .clock (clock),
      .reset (reset),
      .take  (store_it),
      .value (req_tdata),
      .addr  (count_ff[IDX_W-1:0]),
      .wr    (sq_wr)
   );

   always_comb begin
      b0_wr = sq_wr;
      if (merge_we && src_ff) begin
         b0_wr.en   = 1'b1;
         b0_wr.addr = k_ff[IDX_W-1:0];
         b0_wr.data = merge_data;
      end
   end

   ptd_ram #(.DEPTH(MAX_ITEMS), .WIDTH(SQ_W)) u_bank0 (
      .clock     (clock),
      .wr_en     (b0_wr.en),
      .wr_addr   (b0_wr.addr),
      .wr_data   (b0_wr.data),
      .rd_addr_a (rd_a),
      .rd_addr_b (rd_b),
      .rd_data_a (b0_a),
      .rd_data_b (b0_b)
   );

   ptd_ram #(.DEPTH(MAX_ITEMS), .WIDTH(SQ_W)) u_bank1 (
      .clock     (clock),
      .wr_en     (merge_we && !src_ff),
      .wr_addr   (k_ff[IDX_W-1:0]),
      .wr_data   (merge_data),
      .rd_addr_a (rd_a),
      .rd_addr_b (rd_b),
      .rd_data_a (b1_a),
      .rd_data_b (b1_b)
   );

   assign da = src_ff ? b1_a : b0_a;
   assign db = src_ff ? b1_b : b0_b;

   // Head comparison of the two runs; ties go to the left run to keep the sort stable.
   assign take_i     = (i_ff < mid_ff) && ((j_ff >= hi_ff) || (da <= db));
   assign merge_data = take_i ? da : db;
   assign merge_we   = (state_ff == ST_MWR);
   assign sum        = {1'b0, da} + {1'b0, db};
   assign n_wide     = {1'b0, count_ff};
   assign lo_w       = lo_ff + w_ff;
   assign lo_2w      = lo_ff + (w_ff << 1);

   always_comb begin
      rd_a = i_ff[IDX_W-1:0];
      rd_b = j_ff[IDX_W-1:0];
      case (state_ff)
         ST_STOP: rd_a = top_ff[IDX_W-1:0];
         ST_SLP: begin
            rd_a = left_ff[IDX_W-1:0];
            rd_b = right_ff[IDX_W-1:0];
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      src_in       = src_ff;
      w_in         = w_ff;
      lo_in        = lo_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      top_in       = top_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      target_in    = target_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (store_it) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_tlast) begin
                  src_in   = 1'b0;
                  w_in     = WIDE_W'(1);
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            lo_in    = '0;
            state_in = (w_ff >= n_wide) ? ST_SINI : ST_RUN;
         end
         ST_RUN: begin
            if (lo_ff >= n_wide) begin
               w_in     = w_ff << 1;
               src_in   = !src_ff;
               state_in = ST_PASS;
            end else begin
               mid_in   = (lo_w < n_wide) ? lo_w[CNT_W-1:0] : count_ff;
               hi_in    = (lo_2w < n_wide) ? lo_2w[CNT_W-1:0] : count_ff;
               i_in     = lo_ff[CNT_W-1:0];
               j_in     = (lo_w < n_wide) ? lo_w[CNT_W-1:0] : count_ff;
               k_in     = lo_ff[CNT_W-1:0];
               state_in = ST_MRD;
            end
         end
         ST_MRD: state_in = ST_MWR;
         ST_MWR: begin
            if (take_i) begin
               i_in = i_ff + CNT_W'(1);
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
            k_in = k_ff + CNT_W'(1);
            if (k_ff + CNT_W'(1) == hi_ff) begin
               lo_in    = lo_2w;
               state_in = ST_RUN;
            end else begin
               state_in = ST_MRD;
            end
         end
         ST_SINI: begin
            found_in = 1'b0;
            top_in   = count_ff - CNT_W'(1);
            state_in = (count_ff < CNT_W'(3)) ? ST_DONE : ST_STOP;
         end
         ST_STOP: state_in = ST_STGT;
         ST_STGT: begin
            target_in = da;
            left_in   = '0;
            right_in  = top_ff - CNT_W'(1);
            state_in  = ST_SLP;
         end
         ST_SLP: begin
            if (left_ff < right_ff) begin
               state_in = ST_SCMP;
            end else if (top_ff == CNT_W'(2)) begin
               state_in = ST_DONE;
            end else begin
               top_in   = top_ff - CNT_W'(1);
               state_in = ST_STOP;
            end
         end
         ST_SCMP: begin
            if (sum == {1'b0, target_ff}) begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               if (sum < {1'b0, target_ff}) begin
                  left_in = left_ff + CNT_W'(1);
               end else begin
                  right_in = right_ff - CNT_W'(1);
               end
               state_in = ST_SLP;
            end
         end
         ST_DONE: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {drop_ff, found_ff};
               count_in     = '0;
               drop_in      = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      src_ff      <= src_in;
      w_ff        <= w_in;
      lo_ff       <= lo_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      mid_ff      <= mid_in;
      hi_ff       <= hi_in;
      top_ff      <= top_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      target_ff   <= target_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff};

   a_merge_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MWR) |-> (k_ff < hi_ff) && (hi_ff <= count_ff))
      else $error("merge write outside the current run");
   a_ptr_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCMP) |-> (left_ff < right_ff) && (right_ff < top_ff))
      else $error("search pointers out of order");
   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && can_load) |=> (count_ff == '0) && !drop_ff && rsp_tvalid)
      else $error("set state not cleared after result transfer load");
endmodule
`default_nettype wire

[tb/pythagorean_triplet_detector_tb.sv]
// Self-checking testbench for the Pythagorean triplet detector with a built-in predictor.
`timescale 1ns / 1ps
module pythagorean_triplet_detector_tb;
   import ptd_pkg::*;

   typedef struct packed {
      logic [31:0] value;
      logic        last;
   } item_type;

   typedef struct packed {
      logic found;
      logic overflowed;
   } verdict_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;

   item_type    pending_items[$];
   verdict_type expected_verdicts[$];
   int          send_idle_pct;
   int          recv_idle_pct;
   int          error_count;
   int          sets_sent;
   int          verdicts_seen;
   int          found_seen;
   int          overflow_seen;

   // Predictor state: squares of the current set and the drop flag.
   logic [63:0] set_squares[$];
   bit          set_dropped;

   pythagorean_triplet_detector u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit has_triple();
      logic [63:0] sorted[$];
      logic [63:0] sum;
      int top;
      int lo;
      int hi;
      sorted = set_squares;
      sorted.sort();
      if (sorted.size() < 3) return 1'b0;
      for (top = sorted.size() - 1; top >= 2; top--) begin
         lo = 0;
         hi = top - 1;
         while (lo < hi) begin
            sum = sorted[lo] + sorted[hi];
            if (sum == sorted[top]) return 1'b1;
            if (sum < sorted[top]) lo++;
            else hi--;
         end
      end
      return 1'b0;
   endfunction

   task automatic predict_item(input item_type it);
      logic [31:0] mag;
      verdict_type v;
      mag = it.value[31] ? (~it.value + 32'd1) : it.value;
      if (set_squares.size() < MAX_ITEMS) set_squares.push_back(64'(mag) * 64'(mag));
      else set_dropped = 1'b1;
      if (it.last) begin
         v.found = has_triple();
         v.overflowed = set_dropped;
         expected_verdicts.push_back(v);
         set_squares.delete();
         set_dropped = 1'b0;
      end
   endtask

   // Driver: one transfer per handshake; after each one the next item is presented or valid is dropped at random.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_item({req_tdata, req_tlast});
         if (!(req_tvalid && !req_tready)) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               {req_tdata, req_tlast} <= pending_items.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor and receiver stall.
   always @(posedge clock) begin
      verdict_type exp_v;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            verdicts_seen++;
            if (expected_verdicts.size() == 0) begin
               $error("unexpected result transfer, tdata=%h", rsp_tdata);
               error_count++;
            end else begin
               exp_v = expected_verdicts.pop_front();
               found_seen += exp_v.found;
               overflow_seen += exp_v.overflowed;
               if (rsp_tdata[0] !== exp_v.found) begin
                  $error("found: expected %0d, actual %0d", exp_v.found, rsp_tdata[0]);
                  error_count++;
               end
               if (rsp_tdata[1] !== exp_v.overflowed) begin
                  $error("overflowed: expected %0d, actual %0d",
                         exp_v.overflowed, rsp_tdata[1]);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic add_set(input logic [31:0] vals[$]);
      item_type it;
      foreach (vals[i]) begin
         it.value = vals[i];
         it.last = (i == vals.size() - 1);
         pending_items.push_back(it);
      end
      sets_sent++;
   endtask

   function automatic logic [31:0] rand_value(input int kind, input int scale);
      logic [31:0] v;
      case (kind)
         0: v = $urandom;
         1: v = $urandom_range(scale);
         default: v = -$urandom_range(scale);
      endcase
      return v;
   endfunction

   // A short random set; most embed a scaled triple, some a large one.
   task automatic add_random_set();
      logic [31:0] vals[$];
      logic [31:0] t;
      int n;
      int k;
      int pos;
      int j;
      n = ($urandom_range(19) == 0) ? $urandom_range(40, 60) : $urandom_range(1, 8);
      for (j = 0; j < n; j++) vals.push_back(rand_value($urandom_range(2), 30));
      if ($urandom_range(2) != 0) begin
         k = ($urandom_range(3) == 0) ? $urandom_range(1, 100000000) : $urandom_range(1, 10);
         for (j = 0; j < 3; j++) begin
            case (j)
               0: t = 3 * k;
               1: t = 4 * k;
               default: t = 5 * k;
            endcase
            if ($urandom_range(1)) t = -t;
            pos = $urandom_range(vals.size());
            vals.insert(pos, t);
         end
      end
      add_set(vals);
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_tvalid || expected_verdicts.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      logic [31:0] big[$];
      int j;
      int base;
      error_count = 0;
      sets_sent = 0;
      verdicts_seen = 0;
      found_seen = 0;
      overflow_seen = 0;
      send_idle_pct = 30;
      recv_idle_pct = 74;
      set_dropped = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: single item, two items, extremes, plain and negative triples.
      add_set('{32'h8000_0000});
      add_set('{32'd3, 32'd4});
      add_set('{32'd3, 32'd4, 32'd5});
      add_set('{-32'd5, 32'd4, -32'd3});
      add_set('{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0});
      add_set('{32'd0, 32'd0, 32'd0});
      add_set('{32'd1, 32'd2, 32'd3});
      add_set('{32'd0, 32'h8000_0000, 32'h8000_0000});
      // Store full: more than MAX_ITEMS items, the last three dropped but search still runs.
      for (j = 0; j < MAX_ITEMS + 3; j++)
         big.push_back((j < 3) ? 32'(3 + j) : 32'(1000 + 7 * j));
      add_set(big);

      base = pending_items.size();
      while (pending_items.size() < base + 85) add_random_set();
      wait_drained();
      send_idle_pct = 74;
      recv_idle_pct = 30;
      while (pending_items.size() < 85) add_random_set();
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (pending_items.size() < 85) add_random_set();
      wait_drained();
      repeat (50) @(posedge clock);
      $display("Covered %0d sets, %0d results, %0d with a triple, %0d with dropped items.",
               sets_sent, verdicts_seen, found_seen, overflow_seen);
      if (error_count == 0 && expected_verdicts.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
